### rtl/knob_accelerated_setpoint_macros.svh
// Assertion macros for the knob setpoint block.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef KNOB_ACCELERATED_SETPOINT_MACROS_SVH
`define KNOB_ACCELERATED_SETPOINT_MACROS_SVH

// Condition implies consequence in the same cycle.
`define KAS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Condition implies consequence in the following cycle.
`define KAS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/kas_pkg.sv
// Shared types, constants and helper functions for the knob setpoint block.
// No dependencies; imported by kas_step and knob_accelerated_setpoint.
`timescale 1ns / 1ps

package kas_pkg;

  // Mode register codes.
  typedef enum logic [1:0] {
    MODE_LIST   = 2'd0,
    MODE_SPEED  = 2'd1,
    MODE_LINEAR = 2'd2,
    MODE_IGNORE = 2'd3
  } mode_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_MODE        = 3'd0,
    REG_LIST_LOWER  = 3'd1,
    REG_LIST_UPPER  = 3'd2,
    REG_SPEED_LOWER = 3'd3,
    REG_SPEED_UPPER = 3'd4,
    REG_VALUE_LOWER = 3'd5,
    REG_VALUE_UPPER = 3'd6,
    REG_VALUE_INC   = 3'd7
  } reg_idx_t;

  // Gap thresholds in milliseconds and speed step sizes.
  localparam logic [31:0] GAP_MAX     = 32'd1000;
  localparam logic [31:0] GAP_DEFAULT = 32'd200;
  localparam logic [31:0] GAP_SLOW    = 32'd120;
  localparam logic [31:0] GAP_MID     = 32'd50;
  localparam logic [9:0]  STEP_FINE   = 10'd10;
  localparam logic [9:0]  STEP_MID    = 10'd50;
  localparam logic [9:0]  STEP_COARSE = 10'd100;
  localparam logic [15:0] TARGET_KICK = 16'd50;

  // Reset values of the configuration registers.
  localparam logic [9:0]         RST_LIST_UPPER  = 10'd20;
  localparam logic [15:0]        RST_SPEED_UPPER = 16'd4000;
  localparam logic signed [15:0] RST_VALUE_LOWER = 16'sd100;
  localparam logic signed [15:0] RST_VALUE_UPPER = 16'sd100;

  // Direction codes as two-bit signed patterns.
  localparam logic [1:0] DIR_UP       = 2'b01;
  localparam logic [1:0] DIR_DOWN     = 2'b11;
  localparam logic [1:0] DIR_DOWN_TWO = 2'b10;

  typedef struct packed {
    mode_t              mode;
    logic [9:0]         list_lower;
    logic [9:0]         list_upper;
    logic [15:0]        speed_lower;
    logic [15:0]        speed_upper;
    logic signed [15:0] value_lower;
    logic signed [15:0] value_upper;
    logic [9:0]         value_inc;
  } kas_cfg_t;

  typedef struct packed {
    logic [9:0]         list_pos;
    logic [15:0]        target;
    logic signed [15:0] value;
    logic [31:0]        stamp;
  } kas_state_t;

  // Wide enough for every sum of a variable and its move.
  typedef logic signed [17:0] wide_t;

  // Direction times magnitude, without a multiplier.
  function automatic wide_t scaled_move(logic [1:0] dir, logic [9:0] mag);
    wide_t m;
    m = wide_t'({8'b0, mag});
    case (dir)
      DIR_UP:       scaled_move = m;
      DIR_DOWN:     scaled_move = -m;
      DIR_DOWN_TWO: scaled_move = -(m <<< 1);
      default:      scaled_move = '0;
    endcase
  endfunction

  // Lower bound wins first, so inverted bounds give lower below it, else upper.
  function automatic wide_t clamp(wide_t v, wide_t lo, wide_t hi);
    if (v < lo) begin
      clamp = lo;
    end else if (v > hi) begin
      clamp = hi;
    end else begin
      clamp = v;
    end
  endfunction

endpackage

### rtl/kas_step.sv
// Next-state logic for one detent event: list, speed and linear updates, or none in ignore mode.
// Depends on kas_pkg; instantiated by knob_accelerated_setpoint.
`timescale 1ns / 1ps

module kas_step import kas_pkg::*; (
  input  kas_cfg_t   cfg,
  input  kas_state_t cur,
  input  logic [1:0] direction,
  input  logic [31:0] stamp_ms,
  output kas_state_t nxt,
  output logic       speed_changed
);

  logic [31:0] gap;
  logic [31:0] gap_eff;
  logic [9:0]  step;
  wide_t       speed_delta;
  wide_t       speed_sum;
  wide_t       speed_new;
  wide_t       list_sum;
  wide_t       list_new;
  wide_t       value_sum;
  wide_t       value_new;

  always_comb begin
    // Speed step from the time since the previous speed event.
    gap = stamp_ms - cur.stamp;
    if ((gap == '0) || (gap > GAP_MAX)) begin
      gap_eff = GAP_DEFAULT;
    end else begin
      gap_eff = gap;
    end
    if (gap_eff > GAP_SLOW) begin
      step = STEP_FINE;
    end else if (gap_eff > GAP_MID) begin
      step = STEP_MID;
    end else begin
      step = STEP_COARSE;
    end

    speed_delta = scaled_move(direction, step);
    // A rising move from near standstill jumps straight to the coarse step.
    if ((speed_delta > 0) && (cur.target < TARGET_KICK)) begin
      speed_delta = wide_t'({8'b0, STEP_COARSE});
    end
    speed_sum = wide_t'({2'b0, cur.target}) + speed_delta;
    speed_new = clamp(speed_sum, wide_t'({2'b0, cfg.speed_lower}),
                      wide_t'({2'b0, cfg.speed_upper}));

    list_sum = wide_t'({8'b0, cur.list_pos}) + scaled_move(direction, 10'd1);
    list_new = clamp(list_sum, wide_t'({8'b0, cfg.list_lower}),
                     wide_t'({8'b0, cfg.list_upper}));

    value_sum = wide_t'({{2{cur.value[15]}}, cur.value})
                + scaled_move(direction, cfg.value_inc);
    value_new = clamp(value_sum, wide_t'({{2{cfg.value_lower[15]}}, cfg.value_lower}),
                      wide_t'({{2{cfg.value_upper[15]}}, cfg.value_upper}));

    nxt           = cur;
    speed_changed = 1'b0;
    case (cfg.mode)
      MODE_LIST: begin
        nxt.list_pos = list_new[9:0];
      end
      MODE_SPEED: begin
        nxt.target    = speed_new[15:0];
        nxt.stamp     = stamp_ms;
        speed_changed = (speed_new[15:0] != cur.target);
      end
      MODE_LINEAR: begin
        nxt.value = value_new[15:0];
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

endmodule

### rtl/knob_accelerated_setpoint.sv
// Knob setpoint block: turns detent events into a list index, an accelerated
// speed target and a linear value. Each accepted request's result is registered
// in the output register; throughput is one request per clock while the output
// is not stalled, set by the single next-state pass feeding that register. Reset
// (rst_n low, synchronous) restores the register defaults, clears all three
// variables and the previous timestamp, and empties the output register.
`timescale 1ns / 1ps
`include "knob_accelerated_setpoint_macros.svh"

module knob_accelerated_setpoint import kas_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // Detent requests.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [1:0] direction, [33:2] stamp_ms, [39:34] zero
  // Results, one per request.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [9:0] list_position, [25:10] speed_target,
                                  // [41:26] linear_value, [42] speed_changed,
                                  // [47:43] zero
  // Configuration writes, always accepted.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  kas_cfg_t    cfg_r;
  kas_state_t  state_r;
  kas_state_t  state_nxt;
  logic        changed_nxt;
  logic        in_accept;

  logic        out_valid_r;
  logic [9:0]  out_list_r;
  logic [15:0] out_target_r;
  logic [15:0] out_value_r;
  logic        out_changed_r;

  // The output register is the only stage. A new request enters whenever the
  // register is empty or its contents leave in the same cycle, so a waiting
  // result never blocks the next request for more than the stall itself.
  assign in_tready = !out_valid_r || out_tready;
  assign in_accept = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // The next state is computed straight from the request fields and the
  // current variables, and it is committed at the accepting edge. A request in
  // the following cycle therefore already sees the updated variables.
  kas_step u_step (
    .cfg           (cfg_r),
    .cur           (state_r),
    .direction     (in_tdata[1:0]),
    .stamp_ms      (in_tdata[33:2]),
    .nxt           (state_nxt),
    .speed_changed (changed_nxt)
  );

  // Configuration registers. Writes must arrive only while the block is idle; the block does not enforce this.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode        <= MODE_SPEED;
      cfg_r.list_lower  <= '0;
      cfg_r.list_upper  <= RST_LIST_UPPER;
      cfg_r.speed_lower <= '0;
      cfg_r.speed_upper <= RST_SPEED_UPPER;
      cfg_r.value_lower <= RST_VALUE_LOWER;
      cfg_r.value_upper <= RST_VALUE_UPPER;
      cfg_r.value_inc   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_MODE:        cfg_r.mode        <= mode_t'(cfg_data[1:0]);
        REG_LIST_LOWER:  cfg_r.list_lower  <= cfg_data[9:0];
        REG_LIST_UPPER:  cfg_r.list_upper  <= cfg_data[9:0];
        REG_SPEED_LOWER: cfg_r.speed_lower <= cfg_data;
        REG_SPEED_UPPER: cfg_r.speed_upper <= cfg_data;
        REG_VALUE_LOWER: cfg_r.value_lower <= cfg_data;
        REG_VALUE_UPPER: cfg_r.value_upper <= cfg_data;
        REG_VALUE_INC:   cfg_r.value_inc   <= cfg_data[9:0];
        default:         cfg_r             <= cfg_r;
      endcase
    end
  end

  // Knob variables and the timestamp of the last speed event.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (in_accept) begin
      state_r <= state_nxt;
    end
  end

  // Output register: valid is control state, the payload needs no reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_list_r    <= state_nxt.list_pos;
      out_target_r  <= state_nxt.target;
      out_value_r   <= state_nxt.value;
      out_changed_r <= changed_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_changed_r, out_value_r, out_target_r, out_list_r};

  // A stalled result must hold back new requests so it is never overwritten.
  `KAS_ASSERT_NOW(a_no_overwrite, out_valid_r && !out_tready, !in_tready,
    "request accepted while a result was stalled")

  // The change flag is only ever raised by a speed event.
  `KAS_ASSERT_NEXT(a_flag_speed_only, in_accept && (cfg_r.mode != MODE_SPEED),
    !out_changed_r, "speed_changed set outside speed mode")

  // Ignore mode leaves every variable and the timestamp untouched.
  `KAS_ASSERT_NEXT(a_ignore_holds, in_accept && (cfg_r.mode == MODE_IGNORE),
    state_r == $past(state_r), "state changed in ignore mode")

  // With ordered bounds, a speed event leaves the target inside them.
  `KAS_ASSERT_NEXT(a_speed_in_range,
    in_accept && (cfg_r.mode == MODE_SPEED) && (cfg_r.speed_lower <= cfg_r.speed_upper),
    (state_r.target >= $past(cfg_r.speed_lower)) &&
    (state_r.target <= $past(cfg_r.speed_upper)),
    "speed target outside its range")

endmodule
